// ----- design/cce_pkg.sv -----
`timescale 1ns / 1ps
package cce_pkg;

	localparam int DEF_MAX_SLOTS  = 8;
	localparam int DEF_POOL_DEPTH = 16;
	localparam int DEF_MAX_POOLS  = 8;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_NEXT  = 2'd2;

	localparam logic [1:0] REG_NUM_SLOTS = 2'd0;
	localparam logic [1:0] REG_POOL_MAP  = 2'd1;
	localparam logic [1:0] REG_POOL_SIZE = 2'd2;
	localparam logic [1:0] REG_MAX_RES   = 2'd3;

	typedef struct packed {
		logic load_wr;
		logic k_clr;
		logic j_load;
		logic sel_j;
		logic adv_step;
		logic place_step;
		logic rep_init;
		logic rep_rd;
		logic rep_acc;
		logic res_take;
		logic res_zero;
	} cce_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic empty_pool;
		logic j_zero;
		logic fit;
		logic k_at_count;
		logic rep_last;
	} cce_stat_t;

endpackage

// ----- design/cce_dp.sv -----
`timescale 1ns / 1ps
module cce_dp import cce_pkg::*; #(
	parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
	parameter int POOL_DEPTH = DEF_POOL_DEPTH,
	parameter int MAX_POOLS  = DEF_MAX_POOLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic [2:0]  load_pool,
	input  logic [3:0]  load_index,
	input  logic [15:0] load_degree,
	input  logic [6:0]  load_resolution,
	input  cce_cmd_t    cmd,
	output cce_stat_t   stat,
	output logic        found,
	output logic [31:0] combo_indices,
	output logic [18:0] total_degree,
	output logic [6:0]  resolution
);

	localparam int SW = $clog2(MAX_SLOTS + 1);
	localparam int SI = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int NE = MAX_POOLS * POOL_DEPTH;
	localparam int AW = (NE > 1) ? $clog2(NE) : 1;

	logic [3:0]  nslots_q;
	logic [23:0] map_q;
	logic [39:0] sizes_q;
	logic [6:0]  maxres_q;

	logic [3:0]    idx_q [MAX_SLOTS];
	logic [SW-1:0] k_q, j_q;
	logic [15:0]   rd_deg_s1;
	logic [6:0]    rd_res_s1;
	logic [18:0]   sum_q;
	logic [6:0]    min_q;
	logic [15:0]   deg_mem [NE];
	logic [6:0]    res_mem [NE];

	logic [SW-1:0] count, jm;
	logic [2:0]    spool [MAX_SLOTS];
	logic [4:0]    scnt  [MAX_SLOTS];
	logic [SI-1:0] sel, ksel;
	logic [4:0]    low, cand;
	logic          fit, empty;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [31:0]   packed_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nslots_q <= 4'd1;
			map_q    <= '0;
			sizes_q  <= '0;
			maxres_q <= 7'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_SLOTS: nslots_q <= cfg_data[3:0];
				REG_POOL_MAP:  map_q    <= cfg_data[23:0];
				REG_POOL_SIZE: sizes_q  <= cfg_data;
				REG_MAX_RES:   maxres_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		count = (nslots_q > 4'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(nslots_q);
		jm    = j_q - SW'(1);
		sel   = cmd.sel_j ? jm[SI-1:0] : k_q[SI-1:0];
		ksel  = k_q[SI-1:0];
	end

	// pool and clamped pool size per slot
	always_comb begin
		empty = 1'b0;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			spool[s] = map_q[3*s +: 3];
			if ({1'b0, spool[s]} >= 4'(MAX_POOLS))
				scnt[s] = 5'd0;
			else if (sizes_q[5*spool[s] +: 5] > 5'(POOL_DEPTH))
				scnt[s] = 5'(POOL_DEPTH);
			else
				scnt[s] = sizes_q[5*spool[s] +: 5];
			if (SW'(s) < count && scnt[s] == 5'd0)
				empty = 1'b1;
		end
	end

	// lowest index allowed for the selected slot, then the candidate
	always_comb begin
		low = 5'd0;
		for (int p = 0; p < MAX_SLOTS; p++) begin
			if (SI'(p) < sel && spool[p] == spool[sel] && ({1'b0, idx_q[p]} + 5'd1) > low)
				low = {1'b0, idx_q[p]} + 5'd1;
		end
		cand = low;
		if (cmd.sel_j && ({1'b0, idx_q[sel]} + 5'd1) > low)
			cand = {1'b0, idx_q[sel]} + 5'd1;
		fit = cand < scnt[sel];
	end

	always_comb begin
		stat.count_zero = (count == '0);
		stat.empty_pool = empty;
		stat.j_zero     = (j_q == '0);
		stat.fit        = fit;
		stat.k_at_count = (k_q == count);
		stat.rep_last   = ((k_q + SW'(1)) == count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLOTS; s++)
				idx_q[s] <= 4'd0;
			k_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.k_clr || cmd.rep_init)
				k_q <= '0;
			if (cmd.j_load)
				j_q <= count;
			if (cmd.adv_step && j_q != '0) begin
				j_q <= jm;
				if (fit) begin
					idx_q[sel] <= cand[3:0];
					k_q        <= j_q;
				end
			end
			if (cmd.place_step && fit) begin
				idx_q[sel] <= cand[3:0];
				k_q        <= k_q + SW'(1);
			end
			if (cmd.rep_acc)
				k_q <= k_q + SW'(1);
		end
	end

	always_comb begin
		wr_addr = AW'(32'(load_pool) * POOL_DEPTH + 32'(load_index));
		rd_addr = AW'(32'(spool[ksel]) * POOL_DEPTH + 32'(idx_q[ksel]));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && {1'b0, load_pool} < 4'(MAX_POOLS) &&
		    {1'b0, load_index} < 5'(POOL_DEPTH)) begin
			deg_mem[wr_addr] <= load_degree;
			res_mem[wr_addr] <= load_resolution;
		end
		if (cmd.rep_rd) begin
			rd_deg_s1 <= deg_mem[rd_addr];
			rd_res_s1 <= res_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rep_init) begin
			sum_q <= '0;
			min_q <= 7'h7F;
		end else if (cmd.rep_acc) begin
			sum_q <= sum_q + 19'(rd_deg_s1);
			if (rd_res_s1 < min_q)
				min_q <= rd_res_s1;
		end
	end

	always_comb begin
		packed_idx = '0;
		for (int s = 0; s < MAX_SLOTS; s++)
			if (SW'(s) < count)
				packed_idx[4*s +: 4] = idx_q[s];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (cmd.res_take) begin
			found <= 1'b1;
		end else if (cmd.res_zero) begin
			found <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_take) begin
			combo_indices <= packed_idx;
			total_degree  <= sum_q;
			resolution    <= (min_q > maxres_q) ? maxres_q : min_q;
		end else if (cmd.res_zero) begin
			combo_indices <= '0;
			total_degree  <= '0;
			resolution    <= '0;
		end
	end

endmodule

// ----- design/cce_ctrl.sv -----
`timescale 1ns / 1ps
module cce_ctrl import cce_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [1:0] action,
	input  logic      out_ready,
	input  cce_stat_t stat,
	output cce_cmd_t  cmd,
	output logic      in_ready,
	output logic      out_valid
);

	typedef enum logic [2:0] {
		S_IDLE, S_ADV, S_PLACE, S_RD, S_ACC, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic   exhausted_q;
	logic   from_start_q;
	logic   take;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign take      = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (action)
						ACT_LOAD: begin
							cmd.load_wr  = 1'b1;
							cmd.res_zero = 1'b1;
						end
						ACT_START: begin
							cmd.k_clr    = 1'b1;
							cmd.res_zero = stat.count_zero || stat.empty_pool;
						end
						ACT_NEXT: begin
							cmd.j_load   = 1'b1;
							cmd.res_zero = exhausted_q;
						end
						default: cmd.res_zero = 1'b1;
					endcase
				end
			end
			S_ADV: begin
				cmd.sel_j    = 1'b1;
				cmd.adv_step = 1'b1;
				cmd.res_zero = stat.j_zero;
			end
			S_PLACE: begin
				cmd.place_step = !stat.k_at_count;
				cmd.rep_init   = stat.k_at_count;
				cmd.res_zero   = !stat.k_at_count && !stat.fit && from_start_q;
			end
			S_RD:  cmd.rep_rd   = 1'b1;
			S_ACC: cmd.rep_acc  = 1'b1;
			S_FIN: cmd.res_take = 1'b1;
			S_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			exhausted_q  <= 1'b1;
			from_start_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_OUT;
						unique case (action)
							ACT_START: begin
								exhausted_q  <= 1'b1;
								from_start_q <= 1'b1;
								if (!stat.count_zero && !stat.empty_pool)
									state_q <= S_PLACE;
							end
							ACT_NEXT: begin
								from_start_q <= 1'b0;
								if (!exhausted_q)
									state_q <= S_ADV;
							end
							default: ;
						endcase
					end
				end
				S_ADV: begin
					if (stat.j_zero) begin
						exhausted_q <= 1'b1;
						state_q     <= S_OUT;
					end else if (stat.fit) begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (stat.k_at_count) begin
						exhausted_q <= 1'b0;
						state_q     <= S_RD;
					end else if (!stat.fit) begin
						// a failed start ends here; a failed advance carries left
						state_q <= from_start_q ? S_OUT : S_ADV;
					end
				end
				S_RD:  state_q <= S_ACC;
				S_ACC: state_q <= stat.rep_last ? S_FIN : S_RD;
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- design/constrained_combination_enumerator.sv -----
`timescale 1ns / 1ps
// Lexicographic enumerator of constrained combinations, one source per slot.
// Input channel (in_valid/in_ready) takes one word per item: a load writes
// one degree/resolution table entry, a start finds the first combination,
// a next advances it with carry toward slot zero. Every item returns exactly
// one word on the output channel (out_valid/out_ready); found is 0 for a
// load, an unused action, a failed start, or an exhausted enumeration.
// Configuration is a write-only port: cfg_we, cfg_index (0 slot count,
// 1 slot-to-pool map, 2 pool sizes, 3 resolution clamp), cfg_data.
// One item is in flight at a time. A load, an unused action, a start with
// no slots or an empty pool, or an exhausted next offers its result in the
// cycle after it is taken. Otherwise slots are walked one per cycle in the
// placement loop, backing up one slot per cycle on carry, then the table is
// read for each slot in turn, a read state then an accumulate state, and a
// found combination is registered before it is offered. A new item is taken
// the cycle after the result leaves.
// Reset clears the slot indices and marks the enumeration exhausted, so a
// start is needed first; table contents are undefined until loaded.
// While the receiver stalls, the result holds and no new item is taken.
module constrained_combination_enumerator import cce_pkg::*; #(
	parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
	parameter int POOL_DEPTH = DEF_POOL_DEPTH,
	parameter int MAX_POOLS  = DEF_MAX_POOLS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [39:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [2:0]  load_pool,
	input  logic [3:0]  load_index,
	input  logic [15:0] load_degree,
	input  logic [6:0]  load_resolution,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] combo_indices,
	output logic [18:0] total_degree,
	output logic [6:0]  resolution
);

	cce_cmd_t  cmd;
	cce_stat_t stat;
	logic [6:0] maxres_q;

	cce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	cce_dp #(
		.MAX_SLOTS  (MAX_SLOTS),
		.POOL_DEPTH (POOL_DEPTH),
		.MAX_POOLS  (MAX_POOLS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.load_pool       (load_pool),
		.load_index      (load_index),
		.load_degree     (load_degree),
		.load_resolution (load_resolution),
		.cmd             (cmd),
		.stat            (stat),
		.found           (found),
		.combo_indices   (combo_indices),
		.total_degree    (total_degree),
		.resolution      (resolution)
	);

	// shadow of the clamp register for checking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxres_q <= 7'd32;
		end else if (cfg_we && cfg_index == REG_MAX_RES) begin
			maxres_q <= cfg_data[6:0];
		end
	end

`ifndef ASSERT_OFF
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides active together");

	a_load_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && action == ACT_LOAD) |=> (out_valid && !found))
		else $error("load did not return an empty word next cycle");

	a_res_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (resolution <= maxres_q))
		else $error("reported resolution above clamp");
`endif

endmodule
